### hdl/assert_macros.svh
// Assertion macros used by two_way_sorted_merge
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check on the rising clock edge, muted while reset is high
`define ASSERT_CLK(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Concurrent check on the rising clock edge that also holds during reset
`define ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

### hdl/tsm_pkg.sv
// Opcodes, value width, sequencer state codes and source codes for the two-way sorted merge
`default_nettype none

package tsm_pkg;

   localparam logic [1:0] OP_APPEND_A = 2'd0;
   localparam logic [1:0] OP_APPEND_B = 2'd1;
   localparam logic [1:0] OP_MERGE    = 2'd2;

   localparam int VALUE_W = 32;

   localparam logic ST_IDLE  = 1'b0;
   localparam logic ST_MERGE = 1'b1;

   localparam logic SRC_A = 1'b0;
   localparam logic SRC_B = 1'b1;

endpackage

`default_nettype wire

### hdl/tsm_ram.sv
// Generic single-write, single-read RAM with registered read data
`default_nettype none

module tsm_ram #(
   parameter int Width = 32,
   parameter int Depth = 32
) (
   input  wire logic                                     clock,
   input  wire logic                                     wr_en,
   input  wire logic [(Depth > 1 ? $clog2(Depth) : 1)-1:0] wr_addr,
   input  wire logic [Width-1:0]                         wr_data,
   input  wire logic [(Depth > 1 ? $clog2(Depth) : 1)-1:0] rd_addr,
   output logic      [Width-1:0]                         rd_data
);

   logic [Width-1:0] mem_ff [Depth];
   logic [Width-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

### hdl/two_way_sorted_merge.sv
// Top level: list stores, append logic and merge sequencer with output register
//
//   channel | direction | ports                                        | handshake
//   --------+-----------+----------------------------------------------+---------------------
//   req     | in        | req_opcode, req_value                        | req_valid/req_ready
//   rsp     | out       | rsp_merged_value, rsp_source_list, rsp_last  | rsp_valid/rsp_ready
//
// A merge emits one element per cycle while the rsp channel does not stall,
// reading the next list heads through the single read port of each list RAM.
// req_ready is low while a merge runs.
// Synchronous reset empties both lists; the RAM contents are not cleared.
// A stalled rsp channel holds the sequencer in place, one result in the output register.
`default_nettype none
`include "assert_macros.svh"

module two_way_sorted_merge
   import tsm_pkg::*;
#(
   parameter int DEPTH = 32
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       req_valid,
   output logic                            req_ready,
   input  wire logic [1:0]                 req_opcode,
   input  wire logic signed [VALUE_W-1:0]  req_value,
   output logic                            rsp_valid,
   input  wire logic                       rsp_ready,
   output logic signed [VALUE_W-1:0]       rsp_merged_value,
   output logic                            rsp_source_list,
   output logic                            rsp_last
);

   localparam int AddrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CntW  = $clog2(DEPTH + 1);
   localparam logic [CntW-1:0] CntFull = CntW'(DEPTH);
   localparam logic [CntW-1:0] CntOne  = CntW'(1);

   logic                      state_ff, state_in;
   logic [CntW-1:0]           count_a_ff, count_a_in;
   logic [CntW-1:0]           count_b_ff, count_b_in;
   logic [CntW-1:0]           ia_ff, ia_in;
   logic [CntW-1:0]           ib_ff, ib_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   logic signed [VALUE_W-1:0] rsp_value_ff, rsp_value_in;
   logic                      rsp_src_ff, rsp_src_in;
   logic                      rsp_last_ff, rsp_last_in;

   logic               req_fire;
   logic               wr_a, wr_b;
   logic [VALUE_W-1:0] rd_a, rd_b;
   logic               a_left, b_left, take_a, emit_go;

   tsm_ram #(.Width(VALUE_W), .Depth(DEPTH)) u_list_a (
      .clock   (clock),
      .wr_en   (wr_a),
      .wr_addr (count_a_ff[AddrW-1:0]),
      .wr_data (req_value),
      .rd_addr (ia_in[AddrW-1:0]),
      .rd_data (rd_a)
   );

   tsm_ram #(.Width(VALUE_W), .Depth(DEPTH)) u_list_b (
      .clock   (clock),
      .wr_en   (wr_b),
      .wr_addr (count_b_ff[AddrW-1:0]),
      .wr_data (req_value),
      .rd_addr (ib_in[AddrW-1:0]),
      .rd_data (rd_b)
   );

   assign req_ready = (state_ff == ST_IDLE);
   assign req_fire  = req_valid && req_ready;
   assign wr_a = req_fire && (req_opcode == OP_APPEND_A) && (count_a_ff < CntFull);
   assign wr_b = req_fire && (req_opcode == OP_APPEND_B) && (count_b_ff < CntFull);

   // RAM read address is the next index, so during a merge rd_a/rd_b hold the current heads
   assign a_left  = (ia_ff < count_a_ff);
   assign b_left  = (ib_ff < count_b_ff);
   assign take_a  = a_left && (!b_left || ($signed(rd_a) <= $signed(rd_b)));
   assign emit_go = (state_ff == ST_MERGE) && (!rsp_valid_ff || rsp_ready);

   always_comb begin
      state_in     = state_ff;
      count_a_in   = count_a_ff;
      count_b_in   = count_b_ff;
      ia_in        = ia_ff;
      ib_in        = ib_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_value_in = rsp_value_ff;
      rsp_src_in   = rsp_src_ff;
      rsp_last_in  = rsp_last_ff;

      if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (wr_a) begin
               count_a_in = count_a_ff + CntOne;
            end
            if (wr_b) begin
               count_b_in = count_b_ff + CntOne;
            end
            if (req_fire && (req_opcode == OP_MERGE)) begin
               ia_in = '0;
               ib_in = '0;
               // merge of two empty lists emits nothing
               if ((count_a_ff != '0) || (count_b_ff != '0)) begin
                  state_in = ST_MERGE;
               end
            end
         end
         ST_MERGE: begin
            if (emit_go) begin
               rsp_valid_in = 1'b1;
               if (take_a) begin
                  rsp_value_in = $signed(rd_a);
                  rsp_src_in   = SRC_A;
                  rsp_last_in  = ((ia_ff + CntOne) == count_a_ff) && !b_left;
                  ia_in        = ia_ff + CntOne;
               end else begin
                  rsp_value_in = $signed(rd_b);
                  rsp_src_in   = SRC_B;
                  rsp_last_in  = ((ib_ff + CntOne) == count_b_ff) && !a_left;
                  ib_in        = ib_ff + CntOne;
               end
               if (rsp_last_in) begin
                  state_in   = ST_IDLE;
                  count_a_in = '0;
                  count_b_in = '0;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_a_ff   <= '0;
         count_b_ff   <= '0;
         ia_ff        <= '0;
         ib_ff        <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_a_ff   <= count_a_in;
         count_b_ff   <= count_b_in;
         ia_ff        <= ia_in;
         ib_ff        <= ib_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_value_ff <= rsp_value_in;
      rsp_src_ff   <= rsp_src_in;
      rsp_last_ff  <= rsp_last_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_merged_value = rsp_value_ff;
   assign rsp_source_list  = rsp_src_ff;
   assign rsp_last         = rsp_last_ff;

   `ASSERT_CLK(a_merge_nonempty, clock, reset, (state_ff == ST_MERGE) |-> (a_left || b_left), "merge running with both lists drained")
   `ASSERT_CLK(a_idx_bound, clock, reset, (ia_ff <= count_a_ff) || (state_ff == ST_IDLE), "list A index past its count")
   `ASSERT_CLK(a_last_ends, clock, reset, (emit_go && rsp_last_in) |=> ((state_ff == ST_IDLE) && (count_a_ff == '0) && (count_b_ff == '0)), "last transaction did not end the merge")
   `ASSERT_CLK(a_count_cap, clock, reset, (count_a_ff <= CntFull) && (count_b_ff <= CntFull), "list count above depth")

endmodule

`default_nettype wire

### sim/tb_top.sv
// Self-checking testbench for two_way_sorted_merge: list loading, merges, stalls
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import tsm_pkg::*;

   localparam int         LIST_DEPTH  = 32;
   localparam logic [1:0] OP_UNUSED   = 2'd3;
   localparam int         HOLD_CYCLES = 200;
   localparam int         REQ_TARGET  = 210;

   typedef struct {
      logic [1:0]                opcode;
      logic signed [VALUE_W-1:0] value;
   } list_req_type;

   typedef struct {
      logic signed [VALUE_W-1:0] value;
      logic                      src;
      logic                      last;
   } merged_elem_type;

   typedef enum int {RUN_SORTED, RUN_NARROW, RUN_UNSORTED} run_kind_type;

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      req_valid = 1'b0;
   logic                      req_ready;
   logic [1:0]                req_opcode = OP_APPEND_A;
   logic signed [VALUE_W-1:0] req_value = '0;
   logic                      rsp_valid;
   logic                      rsp_ready = 1'b0;
   logic signed [VALUE_W-1:0] rsp_merged_value;
   logic                      rsp_source_list;
   logic                      rsp_last;

   two_way_sorted_merge #(.DEPTH(LIST_DEPTH)) u_top (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_opcode       (req_opcode),
      .req_value        (req_value),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_merged_value (rsp_merged_value),
      .rsp_source_list  (rsp_source_list),
      .rsp_last         (rsp_last)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // stimulus, predicted list contents and pending merge output
   list_req_type              pend_q[$];
   merged_elem_type           merged_q[$];
   logic signed [VALUE_W-1:0] list_a_q[$];
   logic signed [VALUE_W-1:0] list_b_q[$];

   int req_items     = 0;
   int err_count     = 0;
   int result_count  = 0;
   int merge_count   = 0;
   int append_count  = 0;
   int ignored_count = 0;
   int longest_merge = 0;

   // tracks list state per accepted transaction and queues the merged sequence
   function automatic void update_lists(input logic [1:0] opcode,
                                        input logic signed [VALUE_W-1:0] value);
      int              ia;
      int              ib;
      int              total;
      int              k;
      merged_elem_type e;
      ia = 0;
      ib = 0;
      k  = 0;
      case (opcode)
         OP_APPEND_A: begin
            append_count++;
            if (list_a_q.size() < LIST_DEPTH) list_a_q = {list_a_q, value};
         end
         OP_APPEND_B: begin
            append_count++;
            if (list_b_q.size() < LIST_DEPTH) list_b_q = {list_b_q, value};
         end
         OP_MERGE: begin
            merge_count++;
            total = list_a_q.size() + list_b_q.size();
            while (ia < list_a_q.size() || ib < list_b_q.size()) begin
               // ties go to list A
               if (ib >= list_b_q.size() ||
                   (ia < list_a_q.size() && list_a_q[ia] <= list_b_q[ib])) begin
                  e.value = list_a_q[ia];
                  e.src   = SRC_A;
                  ia++;
               end else begin
                  e.value = list_b_q[ib];
                  e.src   = SRC_B;
                  ib++;
               end
               k++;
               e.last = (k == total);
               merged_q = {merged_q, e};
            end
            if (total > longest_merge) longest_merge = total;
            list_a_q.delete();
            list_b_q.delete();
         end
         default: begin
            ignored_count++;
         end
      endcase
   endfunction

   task automatic push_req(input logic [1:0] opcode, input logic signed [VALUE_W-1:0] value);
      list_req_type r;
      r.opcode = opcode;
      r.value  = value;
      pend_q = {pend_q, r};
      if (opcode != OP_UNUSED) req_items++;
   endtask

   function automatic logic signed [VALUE_W-1:0] pick_value(input run_kind_type kind,
                                                            inout longint v, input int span);
      logic signed [VALUE_W-1:0] cur;
      if (kind == RUN_UNSORTED) return $signed($urandom);
      cur = v[VALUE_W-1:0];
      v = v + $urandom_range(0, span);
      if (v > 64'sd2147483647) v = 64'sd2147483647;
      return cur;
   endfunction

   // one load/merge sequence: two lists appended in random interleave, then a merge
   task automatic make_run(input int na, input int nb, input run_kind_type kind);
      logic signed [VALUE_W-1:0] av[$];
      logic signed [VALUE_W-1:0] bv[$];
      longint va;
      longint vb;
      int     span;
      int     ia;
      int     ib;
      case ($urandom_range(0, 2))
         0:       span = 1;
         1:       span = 4096;
         default: span = 1 << 26;
      endcase
      if (kind == RUN_NARROW) begin
         span = 2;
         va = longint'($urandom_range(0, 8)) - 4;
         vb = longint'($urandom_range(0, 8)) - 4;
      end else begin
         va = longint'($signed($urandom));
         vb = longint'($signed($urandom));
      end
      for (int i = 0; i < na; i++) av = {av, pick_value(kind, va, span)};
      for (int i = 0; i < nb; i++) bv = {bv, pick_value(kind, vb, span)};
      ia = 0;
      ib = 0;
      while (ia < na || ib < nb) begin
         if ($urandom_range(0, 15) == 0) push_req(OP_UNUSED, $signed($urandom));
         if (ib >= nb || (ia < na && $urandom_range(0, 1) == 0)) begin
            push_req(OP_APPEND_A, av[ia]);
            ia++;
         end else begin
            push_req(OP_APPEND_B, bv[ib]);
            ib++;
         end
      end
      push_req(OP_MERGE, $signed($urandom));
   endtask

   task automatic build_stimulus();
      int           r;
      int           na;
      int           nb;
      run_kind_type kind;
      // empty merge and unused opcode
      push_req(OP_MERGE, 32'sh8000_0001);
      push_req(OP_UNUSED, 32'shFFFF_FFFF);
      // value extremes in both lists, every pair ties
      push_req(OP_APPEND_A, 32'sh8000_0000);
      push_req(OP_APPEND_B, 32'sh8000_0000);
      push_req(OP_APPEND_A, 32'sh0000_0000);
      push_req(OP_APPEND_B, 32'sh0000_0000);
      push_req(OP_APPEND_B, 32'sh7FFF_FFFF);
      push_req(OP_APPEND_A, 32'sh7FFF_FFFF);
      push_req(OP_MERGE, 32'sh7FFF_FFFF);
      // list B only
      push_req(OP_APPEND_B, -32'sd7);
      push_req(OP_APPEND_B, 32'sd3);
      push_req(OP_MERGE, '0);
      // single element
      push_req(OP_APPEND_A, 32'sd12);
      push_req(OP_MERGE, '0);
      // list A runs out first, B remainder follows
      push_req(OP_APPEND_A, -32'sd5);
      push_req(OP_APPEND_B, 32'sd10);
      push_req(OP_APPEND_B, 32'sd20);
      push_req(OP_APPEND_A, 32'sd15);
      push_req(OP_MERGE, '0);

      // both lists overfilled: appends past full are dropped, longest merge
      make_run(LIST_DEPTH + 2, LIST_DEPTH + 1, RUN_SORTED);
      while (req_items < REQ_TARGET) begin
         r = $urandom_range(0, 19);
         kind = (r < 10) ? RUN_SORTED : (r < 15) ? RUN_NARROW : RUN_UNSORTED;
         na = ($urandom_range(0, 9) == 0) ? $urandom_range(7, LIST_DEPTH + 3)
                                          : $urandom_range(0, 6);
         nb = ($urandom_range(0, 9) == 0) ? $urandom_range(7, LIST_DEPTH + 3)
                                          : $urandom_range(0, 6);
         make_run(na, nb, kind);
      end
   endtask

   // driver: bursts of transactions separated by random gaps
   logic         req_fire = 1'b0;
   int           burst_left = 0;
   int           gap_left = 0;
   list_req_type cur_req;

   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (req_valid && !req_fire) begin
         // hold payload until accepted
      end else if (gap_left > 0) begin
         req_valid <= 1'b0;
         gap_left  <= gap_left - 1;
      end else if (pend_q.size() > 0) begin
         cur_req = pend_q[0];
         pend_q.delete(0);
         req_valid  <= 1'b1;
         req_opcode <= cur_req.opcode;
         req_value  <= cur_req.value;
         if (burst_left <= 1) begin
            burst_left <= $urandom_range(1, 12);
            gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
         end else begin
            burst_left <= burst_left - 1;
         end
      end else begin
         req_valid <= 1'b0;
      end
   end

   // receiver: stall pattern re-chosen each time rx_phase counts down to zero, plus two long hold-offs
   int rx_mode    = 0;
   int rx_phase   = 0;
   int hold_left  = 0;
   int holds_done = 0;
   int hold_mark  = 10;

   always @(negedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            rsp_ready <= 1'b0;
         end else if (holds_done < 2 && result_count >= hold_mark) begin
            hold_left  <= HOLD_CYCLES - 1;
            holds_done <= holds_done + 1;
            hold_mark  <= hold_mark + 190;
            rsp_ready  <= 1'b0;
         end else begin
            case (rx_mode)
               0:       rsp_ready <= 1'b1;
               1:       rsp_ready <= 1'($urandom_range(0, 1));
               2:       rsp_ready <= ($urandom_range(0, 3) == 0);
               default: rsp_ready <= (rx_phase % 3 != 0);
            endcase
         end
         if (rx_phase == 0) begin
            rx_mode  <= $urandom_range(0, 3);
            rx_phase <= 47;
         end else begin
            rx_phase <= rx_phase - 1;
         end
      end
   end

   // monitor: predicts on each request transaction, checks each result transaction
   merged_elem_type want;

   always @(posedge clock) begin
      req_fire <= req_valid && req_ready && !reset;
      if (!reset) begin
         if (req_valid && req_ready) update_lists(req_opcode, req_value);
         if (rsp_valid && rsp_ready) begin
            result_count++;
            if (merged_q.size() == 0) begin
               $display("%0t: result with nothing expected: value=%0d source=%0b last=%0b",
                        $time, rsp_merged_value, rsp_source_list, rsp_last);
               err_count++;
            end else begin
               want = merged_q[0];
               merged_q.delete(0);
               if (rsp_merged_value !== want.value) begin
                  $display("%0t: merged_value expected %0d actual %0d",
                           $time, want.value, rsp_merged_value);
                  err_count++;
               end
               if (rsp_source_list !== want.src) begin
                  $display("%0t: source_list expected %0b actual %0b",
                           $time, want.src, rsp_source_list);
                  err_count++;
               end
               if (rsp_last !== want.last) begin
                  $display("%0t: last expected %0b actual %0b",
                           $time, want.last, rsp_last);
                  err_count++;
               end
            end
         end
      end
   end

   initial begin
      build_stimulus();
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      while (pend_q.size() != 0 || req_valid) @(posedge clock);
      while (merged_q.size() != 0) @(posedge clock);
      repeat (4 * LIST_DEPTH) @(posedge clock);
      if (merged_q.size() != 0) begin
         $display("%0t: %0d merged results never arrived", $time, merged_q.size());
         err_count++;
      end
      $display("covered %0d appends, %0d merges, %0d ignored opcodes; %0d results checked",
               append_count, merge_count, ignored_count, result_count);
      $display("longest merge %0d elements, %0d long receiver hold-offs, %0d mismatches",
               longest_merge, holds_done, err_count);
      if (err_count == 0) begin
         $display("two_way_sorted_merge regression: pass");
      end else begin
         $display("two_way_sorted_merge regression: fail");
      end
      $finish;
   end

   initial begin
      #5_000_000;
      $display("%0t: timeout", $time);
      $display("two_way_sorted_merge regression: fail");
      $finish;
   end

endmodule
